/* rtl/core/i2cm_pkg.sv */
// shared constants and codes for the i2c master line sequencer
// no dependencies; used by the channel interfaces and the top level
package i2cm_pkg;

    localparam int OP_W     = 4;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 7;
    localparam int TICKS_W  = 8;
    localparam int TOUT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int BYTE_BITS = 8;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET = 8'd10;
    localparam logic [TOUT_W-1:0]  ACK_TIMEOUT_RESET = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 4'd0,
        OP_START     = 4'd1,
        OP_STOP      = 4'd2,
        OP_WRITE     = 4'd3,
        OP_ADDR      = 4'd4,
        OP_CHECK_ACK = 4'd5,
        OP_WAIT_ACK  = 4'd6,
        OP_READ      = 4'd7,
        OP_SEND_ACK  = 4'd8,
        OP_SEND_NACK = 4'd9
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_TICKS = 4'd0,
        CFG_ACK_TIMEOUT = 4'd1
    } cfg_idx_t;

endpackage

/* rtl/core/i2cm_if.sv */
// valid/ready channel interfaces: command beats, result beats, register writes
// depends on i2cm_pkg for field widths
interface i2cm_cmd_if;
    import i2cm_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   tx_byte;
    logic [ADDR_W-1:0]   slave_addr;
    logic                rw_bit;
    logic                sda_in;

    modport source (output valid, op, tx_byte, slave_addr, rw_bit, sda_in, input ready);
    modport sink   (input valid, op, tx_byte, slave_addr, rw_bit, sda_in, output ready);
endinterface

interface i2cm_res_if;
    import i2cm_pkg::*;
    logic                valid;
    logic                ready;
    logic                scl_out;
    logic                sda_out;
    logic                busy_res;
    logic                done_res;
    logic [BYTE_W-1:0]   rx_byte;
    logic                ack_level;
    logic                wait_ok;
    logic                bus_held;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_level,
                    wait_ok, bus_held, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_level,
                    wait_ok, bus_held, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/i2c_master_bit_engine.sv */
// i2c master line sequencer: command decode, phase stepping and result buffering
// depends on i2cm_pkg and the channel interfaces in i2cm_if
//
// Usage: every beat on cmd is either a tick (op 0) or a command. While idle a
// command starts its SCL/SDA phase sequence; after that each beat steps the
// sequence, each line change held for phase_ticks beats. Commands seen while
// busy count as ticks. Each accepted beat yields exactly one beat on res with
// the line drives, busy/done flags and the last read byte, ack and wait status.
// cfg writes phase_ticks (index 0) and ack_timeout (index 1); it is always
// ready and should only be used while no sequence is running.
// Each accepted beat's result is registered, in the output register or, while
// res stalls with that register full, in the skid register. Throughput: one
// beat per cycle while cmd is ready, set by the update of the state register.
// The two-entry output buffer (output register plus skid register) keeps cmd
// ready for one beat while res stalls; cmd ready drops only once both are full.
// Reset: lines at SCL low / SDA released, sequencer idle, ack reads as 1,
// registers at phase_ticks 10 and ack_timeout 1000, output buffer empty.
module i2c_master_bit_engine (
    input  logic       clk,
    input  logic       rst_n,
    i2cm_cmd_if.sink   cmd,
    i2cm_res_if.source res,
    i2cm_cfg_if.sink   cfg
);
    import i2cm_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]    cmd;
        logic [2:0]         ph;
        logic [3:0]         bi;
        logic [TICKS_W-1:0] dly;
        logic [BYTE_W-1:0]  sh;
        logic [TOUT_W-1:0]  poll;
        logic               scl;
        logic               sda;
        logic [BYTE_W-1:0]  rx;
        logic               ack;
        logic               ok;
    } state_t;

    typedef struct packed {
        logic               scl_out;
        logic               sda_out;
        logic               busy_res;
        logic               done_res;
        logic [BYTE_W-1:0]  rx_byte;
        logic               ack_level;
        logic               wait_ok;
        logic               bus_held;
    } res_t;

    localparam logic [3:0] BITS_END = 4'(BYTE_BITS);

    logic [TICKS_W-1:0] phase_ticks_reg;
    logic [TOUT_W-1:0]  ack_timeout_reg;
    state_t             st_reg, st_next;
    res_t               new_res;
    res_t               out_data_reg, skid_data_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               step_done;
    logic [TICKS_W-1:0] hold_val;
    logic               cmd_beat, res_beat;

    // line action of the current phase
    function automatic state_t enter(state_t s, logic sda, logic [TICKS_W-1:0] hv,
                                     logic [TOUT_W-1:0] tout);
        state_t r;
        logic   skip_hold;
        r = s;
        skip_hold = 1'b0;
        case (s.cmd)
            OP_START:
                if (s.ph == 3'd0)      r.sda = 1'b1;
                else if (s.ph == 3'd1) r.scl = 1'b1;
                else if (s.ph == 3'd2) r.sda = 1'b0;
                else                   r.scl = 1'b0;
            OP_STOP:
                if (s.ph == 3'd0)      r.sda = 1'b0;
                else if (s.ph == 3'd1) r.scl = 1'b1;
                else if (s.ph == 3'd2) r.sda = 1'b1;
                else                   r.scl = 1'b0;
            OP_WRITE, OP_ADDR:
                if (s.ph == 3'd0)      r.sda = s.sh[BYTE_W-1];
                else if (s.ph == 3'd1) r.scl = 1'b1;
                else                   r.scl = 1'b0;
            OP_CHECK_ACK:
                if (s.ph == 3'd0)
                begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end
                else
                begin
                    r.ack = sda;
                    r.scl = 1'b0;
                end
            OP_WAIT_ACK:
                if (s.ph == 3'd0)
                begin
                    r.sda  = 1'b1;
                    r.scl  = 1'b1;
                    r.poll = '0;
                end
                else if (s.ph == 3'd1)
                begin
                    if (!sda)
                    begin
                        r.ok  = 1'b1;
                        r.ph  = 3'd2;
                        r.scl = 1'b0;
                    end
                    else if (s.poll >= tout)
                    begin
                        r.ok  = 1'b0;
                        r.ph  = 3'd2;
                        r.scl = 1'b0;
                    end
                    else
                    begin
                        // keep polling, no hold while SCL sits high
                        r.poll    = s.poll + 16'd1;
                        skip_hold = 1'b1;
                    end
                end
                else
                    r.scl = 1'b0;
            OP_READ:
                if (s.ph == 3'd0)      r.sda = 1'b1;
                else if (s.ph == 3'd1) r.scl = 1'b1;
                else
                begin
                    r.sh  = {s.sh[BYTE_W-2:0], sda};
                    r.scl = 1'b0;
                end
            OP_SEND_ACK:
                if (s.ph == 3'd0)      r.sda = 1'b0;
                else if (s.ph == 3'd1) r.scl = 1'b1;
                else if (s.ph == 3'd2) r.scl = 1'b0;
                else                   r.sda = 1'b1;
            default:
                if (s.ph == 3'd0)      r.sda = 1'b1;
                else if (s.ph == 3'd1) r.scl = 1'b1;
                else                   r.scl = 1'b0;
        endcase
        if (!skip_hold)
            r.dly = hv;
        return r;
    endfunction

    function automatic state_t finish(state_t s);
        state_t r;
        r     = s;
        r.cmd = OP_TICK;
        r.ph  = '0;
        r.bi  = '0;
        r.dly = '0;
        return r;
    endfunction

    assign hold_val = (phase_ticks_reg == '0) ? 8'd1 : phase_ticks_reg;
    assign cmd_beat = cmd.valid && cmd.ready;
    assign res_beat = out_valid_reg && res.ready;

    always_comb
    begin
        logic [3:0] bi_inc;
        logic [2:0] last;
        st_next   = st_reg;
        step_done = 1'b0;
        bi_inc    = st_reg.bi + 4'd1;
        if (st_reg.cmd == OP_CHECK_ACK)
            last = 3'd1;
        else if (st_reg.cmd == OP_WAIT_ACK || st_reg.cmd == OP_SEND_NACK)
            last = 3'd2;
        else
            last = 3'd3;

        if (st_reg.cmd == OP_TICK)
        begin
            if (cmd.op != OP_TICK && cmd.op <= OP_SEND_NACK)
            begin
                st_next.cmd = cmd.op;
                st_next.ph  = '0;
                st_next.bi  = '0;
                if (cmd.op == OP_WRITE)
                    st_next.sh = cmd.tx_byte;
                else if (cmd.op == OP_ADDR)
                    st_next.sh = {cmd.slave_addr, cmd.rw_bit};
                else if (cmd.op == OP_READ)
                    st_next.sh = '0;
                st_next = enter(st_next, cmd.sda_in, hold_val, ack_timeout_reg);
            end
        end
        else if (st_reg.cmd == OP_WAIT_ACK && st_reg.ph == 3'd1)
            st_next = enter(st_reg, cmd.sda_in, hold_val, ack_timeout_reg);
        else if (st_reg.dly > 8'd1)
            st_next.dly = st_reg.dly - 8'd1;
        else if ((st_reg.cmd == OP_WRITE || st_reg.cmd == OP_ADDR) && st_reg.ph == 3'd2)
        begin
            st_next.sh = {st_reg.sh[BYTE_W-2:0], 1'b0};
            st_next.bi = bi_inc;
            if (bi_inc >= BITS_END)
            begin
                st_next   = finish(st_next);
                step_done = 1'b1;
            end
            else
            begin
                st_next.ph = 3'd0;
                st_next    = enter(st_next, cmd.sda_in, hold_val, ack_timeout_reg);
            end
        end
        else if (st_reg.cmd == OP_READ && st_reg.ph == 3'd2)
        begin
            st_next.bi = bi_inc;
            if (bi_inc >= BITS_END)
            begin
                st_next.rx = st_reg.sh;
                st_next    = finish(st_next);
                step_done  = 1'b1;
            end
            else
            begin
                st_next.ph = 3'd1;
                st_next    = enter(st_next, cmd.sda_in, hold_val, ack_timeout_reg);
            end
        end
        else if (st_reg.ph >= last)
        begin
            st_next   = finish(st_reg);
            step_done = 1'b1;
        end
        else
        begin
            st_next.ph = st_reg.ph + 3'd1;
            st_next    = enter(st_next, cmd.sda_in, hold_val, ack_timeout_reg);
        end
    end

    always_comb
    begin
        new_res.scl_out   = st_next.scl;
        new_res.sda_out   = st_next.sda;
        new_res.busy_res  = (st_next.cmd != OP_TICK);
        new_res.done_res  = step_done;
        new_res.rx_byte   = st_next.rx;
        new_res.ack_level = st_next.ack;
        new_res.wait_ok   = st_next.ok;
        new_res.bus_held  = !cmd.sda_in;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
            st_reg          <= '{cmd: OP_TICK, ph: '0, bi: '0, dly: '0, sh: '0, poll: '0,
                                 scl: 1'b0, sda: 1'b1, rx: '0, ack: 1'b1, ok: 1'b0};
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_PHASE_TICKS: phase_ticks_reg <= cfg.data[TICKS_W-1:0];
                    CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg.data[TOUT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_beat)
                st_reg <= st_next;

            if (cmd_beat)
            begin
                if (!out_valid_reg || res.ready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (res_beat)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_beat)
        begin
            if (!out_valid_reg || res.ready)
                out_data_reg <= new_res;
            else
                skid_data_reg <= new_res;
        end
        else if (res_beat && skid_valid_reg)
            out_data_reg <= skid_data_reg;
    end

    assign cmd.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;

    assign res.valid     = out_valid_reg;
    assign res.scl_out   = out_data_reg.scl_out;
    assign res.sda_out   = out_data_reg.sda_out;
    assign res.busy_res  = out_data_reg.busy_res;
    assign res.done_res  = out_data_reg.done_res;
    assign res.rx_byte   = out_data_reg.rx_byte;
    assign res.ack_level = out_data_reg.ack_level;
    assign res.wait_ok   = out_data_reg.wait_ok;
    assign res.bus_held  = out_data_reg.bus_held;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the i2c master line sequencer: queued command beats,
// a line-level predictor and a result scoreboard
// depends on i2cm_pkg, the channel interfaces in i2cm_if and i2c_master_bit_engine
module tb_top;
    import i2cm_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx_byte;
        logic [ADDR_W-1:0] slave_addr;
        logic              rw_bit;
        logic              sda_in;
    } cmd_beat_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack;
        logic              ok;
        logic              held;
    } line_res_t;

    logic clk = 1'b0;
    logic rst_n;

    i2cm_cmd_if cmd();
    i2cm_res_if res();
    i2cm_cfg_if cfg();

    i2c_master_bit_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // sequencer mirror
    logic [TICKS_W-1:0] hold_ticks;
    logic [TOUT_W-1:0]  poll_limit;
    logic [OP_W-1:0]    seq_cmd;
    logic [2:0]         seq_phase;
    logic [3:0]         seq_bit;
    logic [TICKS_W-1:0] seq_delay;
    logic [BYTE_W-1:0]  seq_shift;
    logic [TOUT_W-1:0]  seq_polls;
    logic               line_scl;
    logic               line_sda;
    logic [BYTE_W-1:0]  rx_last;
    logic               ack_last;
    logic               ok_last;

    cmd_beat_t cmd_backlog[$];
    line_res_t line_expect[$];
    int        beats_queued = 0;
    int        results_checked = 0;
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        stall_req = 0;
    int        stall_served = 0;
    int        stall_left = 0;
    logic      cmd_taken = 1'b0;

    function automatic void end_command();
        seq_cmd   = OP_TICK;
        seq_phase = '0;
        seq_bit   = '0;
        seq_delay = '0;
    endfunction

    // line change made on entry to the current phase
    function automatic void line_action(input logic sda);
        case (seq_cmd)
            OP_START:
                case (seq_phase)
                    3'd0: line_sda = 1'b1;
                    3'd1: line_scl = 1'b1;
                    3'd2: line_sda = 1'b0;
                    default: line_scl = 1'b0;
                endcase
            OP_STOP:
                case (seq_phase)
                    3'd0: line_sda = 1'b0;
                    3'd1: line_scl = 1'b1;
                    3'd2: line_sda = 1'b1;
                    default: line_scl = 1'b0;
                endcase
            OP_WRITE, OP_ADDR:
                case (seq_phase)
                    3'd0: line_sda = seq_shift[BYTE_W-1];
                    3'd1: line_scl = 1'b1;
                    default: line_scl = 1'b0;
                endcase
            OP_CHECK_ACK:
                if (seq_phase == 3'd0)
                begin
                    line_sda = 1'b1;
                    line_scl = 1'b1;
                end
                else
                begin
                    ack_last = sda;
                    line_scl = 1'b0;
                end
            OP_WAIT_ACK:
                if (seq_phase == 3'd0)
                begin
                    line_sda  = 1'b1;
                    line_scl  = 1'b1;
                    seq_polls = '0;
                end
                else if (seq_phase == 3'd1)
                begin
                    if (!sda)
                        ok_last = 1'b1;
                    else if (seq_polls >= poll_limit)
                        ok_last = 1'b0;
                    else
                    begin
                        // still polling, no hold reload
                        seq_polls = seq_polls + 1'b1;
                        return;
                    end
                    seq_phase = 3'd2;
                    line_scl  = 1'b0;
                end
                else
                    line_scl = 1'b0;
            OP_READ:
                case (seq_phase)
                    3'd0: line_sda = 1'b1;
                    3'd1: line_scl = 1'b1;
                    default:
                    begin
                        seq_shift = {seq_shift[BYTE_W-2:0], sda};
                        line_scl  = 1'b0;
                    end
                endcase
            OP_SEND_ACK:
                case (seq_phase)
                    3'd0: line_sda = 1'b0;
                    3'd1: line_scl = 1'b1;
                    3'd2: line_scl = 1'b0;
                    default: line_sda = 1'b1;
                endcase
            default:
                case (seq_phase)
                    3'd0: line_sda = 1'b1;
                    3'd1: line_scl = 1'b1;
                    default: line_scl = 1'b0;
                endcase
        endcase
        seq_delay = (hold_ticks == '0) ? 8'd1 : hold_ticks;
    endfunction

    // leave the current phase, high when the command has finished
    function automatic logic phase_exit(input logic sda);
        logic [2:0] last_phase;
        if ((seq_cmd == OP_WRITE || seq_cmd == OP_ADDR) && seq_phase == 3'd2)
        begin
            seq_shift = seq_shift << 1;
            seq_bit   = seq_bit + 1'b1;
            if (seq_bit >= BYTE_BITS)
            begin
                end_command();
                return 1'b1;
            end
            seq_phase = 3'd0;
            line_action(sda);
            return 1'b0;
        end
        if (seq_cmd == OP_READ && seq_phase == 3'd2)
        begin
            seq_bit = seq_bit + 1'b1;
            if (seq_bit >= BYTE_BITS)
            begin
                rx_last = seq_shift;
                end_command();
                return 1'b1;
            end
            seq_phase = 3'd1;
            line_action(sda);
            return 1'b0;
        end
        if (seq_cmd == OP_CHECK_ACK)
            last_phase = 3'd1;
        else if (seq_cmd == OP_WAIT_ACK || seq_cmd == OP_SEND_NACK)
            last_phase = 3'd2;
        else
            last_phase = 3'd3;
        if (seq_phase >= last_phase)
        begin
            end_command();
            return 1'b1;
        end
        seq_phase = seq_phase + 1'b1;
        line_action(sda);
        return 1'b0;
    endfunction

    function automatic line_res_t step_sequencer(input cmd_beat_t b);
        line_res_t r;
        logic      fin;
        fin = 1'b0;
        // OP_TICK in seq_cmd means idle
        if (seq_cmd == OP_TICK)
        begin
            if (b.op >= OP_START && b.op <= OP_SEND_NACK)
            begin
                seq_cmd   = b.op;
                seq_phase = '0;
                seq_bit   = '0;
                if (b.op == OP_WRITE)
                    seq_shift = b.tx_byte;
                else if (b.op == OP_ADDR)
                    seq_shift = {b.slave_addr, b.rw_bit};
                else if (b.op == OP_READ)
                    seq_shift = '0;
                line_action(b.sda_in);
            end
        end
        else if (seq_cmd == OP_WAIT_ACK && seq_phase == 3'd1)
            line_action(b.sda_in);
        else if (seq_delay > 8'd1)
            seq_delay = seq_delay - 1'b1;
        else
            fin = phase_exit(b.sda_in);
        r.scl  = line_scl;
        r.sda  = line_sda;
        r.busy = (seq_cmd != OP_TICK);
        r.done = fin;
        r.rx   = rx_last;
        r.ack  = ack_last;
        r.ok   = ok_last;
        r.held = ~b.sda_in;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // command driver, one beat held until taken
    always @(negedge clk)
    begin : drive_cmd
        cmd_beat_t nxt;
        if (rst_n && (!cmd.valid || cmd_taken))
        begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = cmd_backlog.pop_front();
                cmd.valid      <= 1'b1;
                cmd.op         <= nxt.op;
                cmd.tx_byte    <= nxt.tx_byte;
                cmd.slave_addr <= nxt.slave_addr;
                cmd.rw_bit     <= nxt.rw_bit;
                cmd.sda_in     <= nxt.sda_in;
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // result sink with random stalls and an occasional long hold-off
    always @(negedge clk)
    begin : drive_res
        if (stall_req != stall_served)
        begin
            stall_served = stall_req;
            stall_left   = 300;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : watch
        line_res_t want;
        line_res_t got;
        cmd_taken <= rst_n && cmd.valid === 1'b1 && cmd.ready === 1'b1;
        if (rst_n && cmd.valid === 1'b1 && cmd.ready === 1'b1)
            line_expect.push_back(step_sequencer({cmd.op, cmd.tx_byte, cmd.slave_addr,
                                                  cmd.rw_bit, cmd.sda_in}));
        if (rst_n && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            got = {res.scl_out, res.sda_out, res.busy_res, res.done_res, res.rx_byte,
                   res.ack_level, res.wait_ok, res.bus_held};
            if (line_expect.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, got %h",
                         $time, got);
                fail_count++;
            end
            else
            begin
                want = line_expect.pop_front();
                check_field("scl_out", 8'(want.scl), 8'(got.scl));
                check_field("sda_out", 8'(want.sda), 8'(got.sda));
                check_field("busy_res", 8'(want.busy), 8'(got.busy));
                check_field("done_res", 8'(want.done), 8'(got.done));
                check_field("rx_byte", want.rx, got.rx);
                check_field("ack_level", 8'(want.ack), 8'(got.ack));
                check_field("wait_ok", 8'(want.ok), 8'(got.ok));
                check_field("bus_held", 8'(want.held), 8'(got.held));
                results_checked++;
            end
        end
    end

    task automatic push_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                             input logic [ADDR_W-1:0] addr, input logic rw, input logic sda);
        cmd_backlog.push_back({op, tx, addr, rw, sda});
        beats_queued++;
    endtask

    // ticks with sda low at low_pct, noise_pct of them carrying a random op
    task automatic push_ticks(input int n, input int low_pct, input int noise_pct);
        logic [OP_W-1:0] op;
        repeat (n)
        begin
            op = OP_TICK;
            if ($urandom_range(99) < noise_pct)
                op = OP_W'($urandom_range(15));
            push_beat(op, BYTE_W'($urandom_range(255)), ADDR_W'($urandom_range(127)),
                      1'($urandom_range(1)), $urandom_range(99) >= low_pct);
        end
    endtask

    // ticks a command needs after its accepting beat, polls not counted
    function automatic int span_of(input logic [OP_W-1:0] op);
        int per;
        per = (hold_ticks == '0) ? 1 : int'(hold_ticks);
        case (op)
            OP_START, OP_STOP, OP_SEND_ACK: return 4 * per;
            OP_WRITE, OP_ADDR:              return 24 * per;
            OP_CHECK_ACK:                   return 2 * per;
            OP_WAIT_ACK:                    return 2 * per;
            OP_READ:                        return 17 * per;
            OP_SEND_NACK:                   return 3 * per;
            default:                        return 0;
        endcase
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                            input logic [ADDR_W-1:0] addr, input logic rw, input int slack,
                            input int low_pct, input int noise_pct);
        int n;
        push_beat(op, tx, addr, rw, 1'($urandom_range(1)));
        n = span_of(op) + slack;
        if (n < 0)
            n = 0;
        push_ticks(n, low_pct, noise_pct);
    endtask

    // mostly just enough ticks, now and then one short so the next command is ignored
    function automatic int jitter();
        if ($urandom_range(9) == 0)
            return -1;
        return $urandom_range(2);
    endfunction

    task automatic send_rand(input logic [OP_W-1:0] op, input int low_pct);
        send_cmd(op, BYTE_W'($urandom_range(255)), ADDR_W'($urandom_range(127)),
                 1'($urandom_range(1)), jitter(), low_pct, 3);
    endtask

    task automatic send_ack_step();
        if ($urandom_range(1))
            send_rand(OP_CHECK_ACK, 50);
        else
            send_cmd(OP_WAIT_ACK, BYTE_W'($urandom_range(255)), ADDR_W'($urandom_range(127)),
                     1'($urandom_range(1)), jitter() + $urandom_range(6), 30, 3);
    endtask

    // start, address, ack, a few data bytes, stop
    task automatic push_transfer();
        logic rd;
        rd = 1'($urandom_range(1));
        send_rand(OP_START, 50);
        send_cmd(OP_ADDR, BYTE_W'($urandom_range(255)), ADDR_W'($urandom_range(127)), rd,
                 jitter(), 50, 3);
        send_ack_step();
        repeat ($urandom_range(1, 3))
        begin
            if (rd)
            begin
                send_rand(OP_READ, 50);
                send_rand($urandom_range(1) ? OP_SEND_ACK : OP_SEND_NACK, 50);
            end
            else
            begin
                send_rand(OP_WRITE, 50);
                send_ack_step();
            end
        end
        send_rand(OP_STOP, 50);
    endtask

    task automatic push_noise();
        repeat ($urandom_range(1, 6))
            push_beat(OP_W'($urandom_range(15)), BYTE_W'($urandom_range(255)),
                      ADDR_W'($urandom_range(127)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        push_ticks($urandom_range(8), 50, 0);
    endtask

    task automatic wait_drained();
        while (results_checked != beats_queued)
            @(negedge clk);
    endtask

    // all results in and the sequencer back to idle
    task automatic settle();
        wait_drained();
        while (seq_cmd != OP_TICK)
        begin
            push_ticks(32, 100, 0);
            wait_drained();
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        if (idx == CFG_PHASE_TICKS)
            hold_ticks = val[TICKS_W-1:0];
        else
            poll_limit = val[TOUT_W-1:0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic run_random(input int pt, input int tout, input int budget,
                              input bit hold_off);
        int first;
        write_reg(CFG_PHASE_TICKS, CFG_DATA_W'(pt));
        write_reg(CFG_ACK_TIMEOUT, CFG_DATA_W'(tout));
        first = beats_queued;
        while (beats_queued - first < budget)
        begin
            if ($urandom_range(9) < 8)
                push_transfer();
            else
                push_noise();
        end
        if (hold_off)
            stall_req++;
        settle();
    endtask

    initial
    begin
        cmd.valid      = 1'b0;
        cmd.op         = OP_TICK;
        cmd.tx_byte    = '0;
        cmd.slave_addr = '0;
        cmd.rw_bit     = 1'b0;
        cmd.sda_in     = 1'b1;
        res.ready      = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = CFG_PHASE_TICKS;
        cfg.data       = '0;
        hold_ticks = PHASE_TICKS_RESET;
        poll_limit = ACK_TIMEOUT_RESET;
        seq_cmd    = OP_TICK;
        seq_phase  = '0;
        seq_bit    = '0;
        seq_delay  = '0;
        seq_shift  = '0;
        seq_polls  = '0;
        line_scl   = 1'b0;
        line_sda   = 1'b1;
        rx_last    = '0;
        ack_last   = 1'b1;
        ok_last    = 1'b0;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 56;

        // register values straight out of reset
        send_cmd(OP_START, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_CHECK_ACK, 8'h00, 7'h00, 1'b0, 0, 100, 0);
        send_cmd(OP_WAIT_ACK, 8'h00, 7'h00, 1'b0, 6, 20, 0);
        send_cmd(OP_STOP, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        settle();

        write_reg(CFG_PHASE_TICKS, 16'd1);
        write_reg(CFG_ACK_TIMEOUT, 16'd2);
        send_cmd(OP_START, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_WRITE, 8'hFF, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_WRITE, 8'h00, 7'h7F, 1'b1, 0, 50, 0);
        send_cmd(OP_ADDR, 8'hFF, 7'h7F, 1'b1, 0, 50, 0);
        send_cmd(OP_ADDR, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_CHECK_ACK, 8'h00, 7'h00, 1'b0, 0, 100, 0);
        send_cmd(OP_CHECK_ACK, 8'h00, 7'h00, 1'b0, 0, 0, 0);
        // sda never low: wait runs out of polls
        send_cmd(OP_WAIT_ACK, 8'h00, 7'h00, 1'b0, 3, 0, 0);
        // high on the first two samples, low on the third
        push_beat(OP_WAIT_ACK, 8'h00, 7'h00, 1'b0, 1'b1);
        push_ticks(2, 0, 0);
        push_ticks(1, 100, 0);
        push_ticks(2, 50, 0);
        send_cmd(OP_READ, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_READ, 8'h00, 7'h00, 1'b0, 0, 0, 0);
        send_cmd(OP_SEND_ACK, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_SEND_NACK, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        send_cmd(OP_STOP, 8'h00, 7'h00, 1'b0, 0, 50, 0);
        push_beat(4'd15, 8'hA5, 7'h2A, 1'b1, 1'b0);
        push_beat(4'd10, 8'h5A, 7'h55, 1'b0, 1'b1);
        // command offered while busy is taken as a tick
        push_beat(OP_START, 8'h00, 7'h00, 1'b0, 1'b1);
        push_beat(OP_WRITE, 8'h3C, 7'h00, 1'b0, 1'b1);
        push_ticks(span_of(OP_START), 50, 0);
        push_beat(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0);
        settle();

        run_random(1, 4, 150, 1'b1);
        run_random(0, 0, 80, 1'b0);

        send_idle_pct = 56;
        recv_idle_pct = 36;
        run_random(2, 1, 120, 1'b0);
        run_random(1, 65535, 50, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(1, 2, 100, 1'b0);

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
